// ===== hdl/gwc_pkg.sv =====
package gwc_pkg;

  // Bank size default
  localparam int unsigned NUM_FEATURES_DEF = 256;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMA_NOISE = 2'd2;

  localparam int unsigned REG_W = 31;
  localparam logic [REG_W-1:0] INIT_COV_RST = 31'd65536000;
  localparam logic [REG_W-1:0] NOISE_RST    = 31'd655;

  // Q16.16 constants
  localparam logic [31:0] Q_ONE     = 32'd65536;
  localparam logic [31:0] SIGMA_MAX = 32'h7FFF_FFFF;
  localparam logic [16:0] MIN_GAIN  = 17'd66;
  localparam logic [16:0] GAIN_ONE  = 17'd65536;

  // Parity codes
  localparam logic [1:0] PAR_ZERO = 2'd0;
  localparam logic [1:0] PAR_POS  = 2'd1;
  localparam logic [1:0] PAR_NEG  = 2'd2;

  // Divider step counts: gain quotient fits 17 bits, shrink quotient 32 bits
  localparam logic [5:0] DIV_SHORT_STEPS = 6'd17;
  localparam logic [5:0] DIV_LONG_STEPS  = 6'd32;
  localparam logic [5:0] SQRT_STEPS      = 6'd32;

  typedef struct packed {
    logic               op;
    logic [7:0]         feature_index;
    logic signed [31:0] response_value;
    logic               is_foreground;
  } in_t;

  typedef struct packed {
    logic               hypothesis_positive;
    logic               misclassified;
    logic signed [31:0] decision_threshold;
    logic               parity_positive;
  } out_t;

  // One Gaussian of the bank
  typedef struct packed {
    logic signed [31:0] mean;
    logic [31:0]        sigma;
    logic [31:0]        cov_mean;
    logic [31:0]        cov_sigma;
  } dist_t;

  // Per-feature decision
  typedef struct packed {
    logic [1:0]         parity;
    logic signed [31:0] threshold;
  } thr_t;

  // Status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== hdl/gaussian_weak_classifier_bank.sv =====
// Channel   | Direction | Signals                          | Item accepted when
// ----------+-----------+----------------------------------+----------------------------
// in        | input     | in_valid_i, in_stall_o, in_data_i | in_valid_i && !in_stall_o
// out       | output    | out_valid_o, out_stall_i, out_data_o | out_valid_o && !out_stall_i
// cfg       | input     | cfg_we_i, cfg_idx_i, cfg_wdata_i  | cfg_we_i
//
// A classify-only item runs the index reduction (NUM_FEATURES subtracted from
// feature_index until in range), the reads and the output. An update item runs the
// shared radix-2 divider (17 + 32 + 17 + 32 steps), the 32-step square root and the
// shared 33x33 multiplier used nine times. After reset, and after each write of
// initial_covariance, a clearing pass runs over both stores; no item is taken
// then. The output register holds a result while out_stall_i is high.
module gaussian_weak_classifier_bank #(
  parameter int unsigned NUM_FEATURES = gwc_pkg::NUM_FEATURES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  gwc_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output gwc_pkg::out_t                  out_data_o,
  input  logic                           cfg_we_i,
  input  logic [gwc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gwc_pkg::REG_W-1:0]      cfg_wdata_i
);

  localparam int unsigned DDEPTH = 2 * NUM_FEATURES;
  localparam int unsigned DAW    = $clog2(DDEPTH);
  localparam int unsigned FAW    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam logic [13:0] NF_X   = 14'(NUM_FEATURES);
  localparam logic [DAW-1:0] DLAST = DAW'(DDEPTH - 1);

  // Sequencer states
  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MOD  = 5'd1;
  localparam logic [4:0] S_LD   = 5'd2;
  localparam logic [4:0] S_K1   = 5'd3;
  localparam logic [4:0] S_M1   = 5'd4;
  localparam logic [4:0] S_M2   = 5'd5;
  localparam logic [4:0] S_M3   = 5'd6;
  localparam logic [4:0] S_P1   = 5'd7;
  localparam logic [4:0] S_K2   = 5'd8;
  localparam logic [4:0] S_D1   = 5'd9;
  localparam logic [4:0] S_D2   = 5'd10;
  localparam logic [4:0] S_D3   = 5'd11;
  localparam logic [4:0] S_D4   = 5'd12;
  localparam logic [4:0] S_D5   = 5'd13;
  localparam logic [4:0] S_D6   = 5'd14;
  localparam logic [4:0] S_D7   = 5'd15;
  localparam logic [4:0] S_D8   = 5'd16;
  localparam logic [4:0] S_D9   = 5'd17;
  localparam logic [4:0] S_D10  = 5'd18;
  localparam logic [4:0] S_P2   = 5'd19;
  localparam logic [4:0] S_SQ   = 5'd20;
  localparam logic [4:0] S_WR   = 5'd21;
  localparam logic [4:0] S_THR  = 5'd22;
  localparam logic [4:0] S_OUT  = 5'd23;

  // Control registers
  logic [4:0]     state_q, state_d;
  logic           clr_act_q, clr_act_d;
  logic [DAW-1:0] clr_q, clr_d;
  logic [30:0]    cov_q, cov_d, rm_q, rm_d, rs_q, rs_d;
  logic           out_valid_q, out_valid_d;

  // Datapath registers
  logic               op_q, op_d, fg_q, fg_d;
  logic [7:0]         f_q, f_d;
  logic signed [31:0] v_q, v_d, mean_q, mean_d, mnew_q, mnew_d, thr_q, thr_d;
  logic [30:0]        sig_q, sig_d;
  logic [31:0]        pm_q, pm_d, ps_q, ps_d, covm_q, covm_d, covs_q, covs_d;
  logic [31:0]        sgn_q, sgn_d;
  logic [32:0]        den_q, den_d;
  logic [16:0]        k_q, k_d;
  logic [47:0]        a_q, a_d;
  logic [48:0]        acc_q, acc_d;
  logic [49:0]        s_q, s_d;
  logic [1:0]         par_q, par_d;
  logic signed [65:0] prod_q;
  gwc_pkg::out_t      out_q, out_d;

  // Shared multiplier operands
  logic signed [32:0] mul_a, mul_b;

  // Unit hookups
  logic                  div_start, div_long, sq_start;
  logic [63:0]           div_num;
  logic [32:0]           div_den;
  logic [31:0]           div_quo, sq_root;
  gwc_pkg::unit_status_t div_stat, sq_stat;

  // Memory ports
  logic                  dist_we, thr_we;
  logic [DAW-1:0]        dist_waddr, dist_raddr;
  logic [FAW-1:0]        thr_waddr, thr_raddr;
  gwc_pkg::dist_t        dist_wdata, dist_rd;
  gwc_pkg::thr_t         thr_wdata, thr_rd;

  // Helpers
  logic [13:0]        f_x, d_x, o_x, clr_x;
  logic signed [32:0] v_minus_mean, diff, ad, vdiff, msum2;
  logic signed [65:0] rnd;
  logic signed [49:0] msum;
  logic signed [31:0] msat, other_mean, mfg, mbg;
  logic [65:0]        t_sum;
  logic [49:0]        term;
  logic [16:0]        gain, omk;
  logic [31:0]        root_sat;
  logic               hyp;

  assign f_x   = {6'd0, f_q};
  assign d_x   = {f_x[12:0], fg_q};
  assign o_x   = {f_x[12:0], ~fg_q};
  assign clr_x = 14'(clr_q) >> 1;

  assign thr_raddr  = f_x[FAW-1:0];
  assign dist_raddr = (state_q == S_WR) ? o_x[DAW-1:0] : d_x[DAW-1:0];

  // Arithmetic on registered values
  always_comb begin
    v_minus_mean = {v_q[31], v_q} - {mean_q[31], mean_q};
    rnd  = prod_q + 66'sd32768;
    msum = {{18{mean_q[31]}}, mean_q} + rnd[65:16];
    if (msum > 50'sd2147483647) begin
      msat = 32'sh7FFF_FFFF;
    end else if (msum < -50'sd2147483648) begin
      msat = 32'sh8000_0000;
    end else begin
      msat = msum[31:0];
    end
    diff  = {mnew_q[31], mnew_q} - {v_q[31], v_q};
    ad    = diff[32] ? -diff : diff;
    t_sum = {1'b0, prod_q[32:0], 32'd0} + {17'd0, acc_q};
    term  = t_sum[65:16];
    gain  = (div_quo[16:0] < gwc_pkg::MIN_GAIN) ? gwc_pkg::MIN_GAIN : div_quo[16:0];
    omk   = gwc_pkg::GAIN_ONE - k_q;
    if (sq_root > gwc_pkg::SIGMA_MAX) begin
      root_sat = gwc_pkg::SIGMA_MAX;
    end else if (sq_root <= gwc_pkg::Q_ONE) begin
      root_sat = gwc_pkg::Q_ONE;
    end else begin
      root_sat = sq_root;
    end
    other_mean = dist_rd.mean;
    mfg   = fg_q ? mnew_q : other_mean;
    mbg   = fg_q ? other_mean : mnew_q;
    msum2 = {mfg[31], mfg} + {mbg[31], mbg};
    vdiff = {v_q[31], v_q} - {thr_q[31], thr_q};
    case (par_q)
      gwc_pkg::PAR_POS: hyp = (vdiff > 33'sd0);
      gwc_pkg::PAR_NEG: hyp = (vdiff < 33'sd0);
      default:          hyp = 1'b0;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    clr_act_d   = clr_act_q;
    clr_d       = clr_q;
    cov_d       = cov_q;
    rm_d        = rm_q;
    rs_d        = rs_q;
    out_valid_d = out_valid_q;
    op_d = op_q;  fg_d = fg_q;  f_d = f_q;  v_d = v_q;
    mean_d = mean_q;  mnew_d = mnew_q;  thr_d = thr_q;  par_d = par_q;
    sig_d = sig_q;  pm_d = pm_q;  ps_d = ps_q;  covm_d = covm_q;  covs_d = covs_q;
    sgn_d = sgn_q;  den_d = den_q;  k_d = k_q;  a_d = a_q;  acc_d = acc_q;  s_d = s_q;
    out_d = out_q;
    mul_a = '0;
    mul_b = '0;
    div_start = 1'b0;
    div_long  = 1'b0;
    div_num   = '0;
    div_den   = '0;
    sq_start  = 1'b0;
    dist_we    = 1'b0;
    dist_waddr = d_x[DAW-1:0];
    dist_wdata = '{mean: mnew_q, sigma: sgn_q, cov_mean: covm_q, cov_sigma: covs_q};
    thr_we     = 1'b0;
    thr_waddr  = f_x[FAW-1:0];
    thr_wdata  = '{parity: par_d, threshold: thr_d};

    // Drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          op_d    = in_data_i.op;
          fg_d    = in_data_i.is_foreground;
          f_d     = in_data_i.feature_index;
          v_d     = in_data_i.response_value;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        // Reduce the index, issue the reads when in range
        if (f_x >= NF_X) begin
          f_d = 8'(f_x - NF_X);
        end else begin
          state_d = S_LD;
        end
      end
      S_LD: begin
        mean_d = dist_rd.mean;
        sig_d  = dist_rd.sigma[30:0];
        pm_d   = dist_rd.cov_mean;
        ps_d   = dist_rd.cov_sigma;
        thr_d  = thr_rd.threshold;
        par_d  = thr_rd.parity;
        if (op_q) begin
          state_d = S_OUT;
        end else begin
          den_d     = {1'b0, dist_rd.cov_mean} + {2'b00, rm_q};
          div_start = 1'b1;
          div_num   = {16'd0, dist_rd.cov_mean, 16'd0};
          div_den   = den_d;
          state_d   = S_K1;
        end
      end
      S_K1: begin
        if (div_stat.done) begin
          k_d     = gain;
          state_d = S_M1;
        end
      end
      S_M1: begin
        mul_a   = {16'd0, k_q};
        mul_b   = v_minus_mean;
        state_d = S_M2;
      end
      S_M2: begin
        mnew_d  = msat;
        mul_a   = {1'b0, pm_q};
        mul_b   = {2'b00, rm_q};
        state_d = S_M3;
      end
      S_M3: begin
        div_start = 1'b1;
        div_long  = 1'b1;
        div_num   = prod_q[63:0];
        div_den   = den_q;
        state_d   = S_P1;
      end
      S_P1: begin
        if (div_stat.done) begin
          covm_d    = div_quo;
          den_d     = {1'b0, ps_q} + {2'b00, rs_q};
          div_start = 1'b1;
          div_num   = {16'd0, ps_q, 16'd0};
          div_den   = den_d;
          state_d   = S_K2;
        end
      end
      S_K2: begin
        if (div_stat.done) begin
          k_d     = gain;
          state_d = S_D1;
        end
      end
      S_D1: begin
        mul_a   = {1'b0, ad[31:0]};
        mul_b   = {1'b0, ad[31:0]};
        state_d = S_D2;
      end
      S_D2: begin
        a_d     = prod_q[63:16];
        state_d = S_D3;
      end
      S_D3: begin
        mul_a   = {1'b0, a_q[31:0]};
        mul_b   = {16'd0, k_q};
        state_d = S_D4;
      end
      S_D4: begin
        acc_d   = prod_q[48:0];
        mul_a   = {17'd0, a_q[47:32]};
        mul_b   = {16'd0, k_q};
        state_d = S_D5;
      end
      S_D5: begin
        s_d     = term;
        mul_a   = {2'b00, sig_q};
        mul_b   = {2'b00, sig_q};
        state_d = S_D6;
      end
      S_D6: begin
        a_d     = prod_q[63:16];
        state_d = S_D7;
      end
      S_D7: begin
        mul_a   = {1'b0, a_q[31:0]};
        mul_b   = {16'd0, omk};
        state_d = S_D8;
      end
      S_D8: begin
        acc_d   = prod_q[48:0];
        mul_a   = {17'd0, a_q[47:32]};
        mul_b   = {16'd0, omk};
        state_d = S_D9;
      end
      S_D9: begin
        s_d     = s_q + term;
        mul_a   = {1'b0, ps_q};
        mul_b   = {2'b00, rs_q};
        state_d = S_D10;
      end
      S_D10: begin
        div_start = 1'b1;
        div_long  = 1'b1;
        div_num   = prod_q[63:0];
        div_den   = den_q;
        state_d   = S_P2;
      end
      S_P2: begin
        if (div_stat.done) begin
          covs_d = div_quo;
          if (s_q[49:48] != 2'b00) begin
            sgn_d   = gwc_pkg::SIGMA_MAX;
            state_d = S_WR;
          end else begin
            sq_start = 1'b1;
            state_d  = S_SQ;
          end
        end
      end
      S_SQ: begin
        if (sq_stat.done) begin
          sgn_d   = root_sat;
          state_d = S_WR;
        end
      end
      S_WR: begin
        // Store the Gaussian, fetch the other class
        dist_we = 1'b1;
        state_d = S_THR;
      end
      S_THR: begin
        thr_d     = msum2[32:1];
        par_d     = (mfg > mbg) ? gwc_pkg::PAR_POS : gwc_pkg::PAR_NEG;
        thr_we    = 1'b1;
        thr_wdata = '{parity: par_d, threshold: thr_d};
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d               = 1'b1;
          out_d.hypothesis_positive = hyp;
          out_d.misclassified       = !op_q && (hyp != fg_q);
          out_d.decision_threshold  = thr_q;
          out_d.parity_positive     = (par_q == gwc_pkg::PAR_POS);
          state_d                   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Sweep both stores back to reset values
    if (clr_act_q) begin
      dist_we    = 1'b1;
      dist_waddr = clr_q;
      dist_wdata = '{mean: '0, sigma: gwc_pkg::Q_ONE,
                     cov_mean: {1'b0, cov_q}, cov_sigma: {1'b0, cov_q}};
      thr_we     = 1'b1;
      thr_waddr  = clr_x[FAW-1:0];
      thr_wdata  = '{parity: gwc_pkg::PAR_ZERO, threshold: '0};
      if (clr_q == DLAST) begin
        clr_act_d = 1'b0;
      end else begin
        clr_d = clr_q + 1'b1;
      end
    end

    // Take configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        gwc_pkg::CFG_INIT_COV: begin
          cov_d     = cfg_wdata_i;
          clr_act_d = 1'b1;
          clr_d     = '0;
        end
        gwc_pkg::CFG_MEAN_NOISE:  rm_d = cfg_wdata_i;
        gwc_pkg::CFG_SIGMA_NOISE: rs_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      clr_act_q   <= 1'b1;
      clr_q       <= '0;
      cov_q       <= gwc_pkg::INIT_COV_RST;
      rm_q        <= gwc_pkg::NOISE_RST;
      rs_q        <= gwc_pkg::NOISE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_act_q   <= clr_act_d;
      clr_q       <= clr_d;
      cov_q       <= cov_d;
      rm_q        <= rm_d;
      rs_q        <= rs_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  fg_q <= fg_d;  f_q <= f_d;  v_q <= v_d;
    mean_q <= mean_d;  mnew_q <= mnew_d;  thr_q <= thr_d;  par_q <= par_d;
    sig_q <= sig_d;  pm_q <= pm_d;  ps_q <= ps_d;  covm_q <= covm_d;  covs_q <= covs_d;
    sgn_q <= sgn_d;  den_q <= den_d;  k_q <= k_d;  a_q <= a_d;  acc_q <= acc_d;
    s_q <= s_d;  out_q <= out_d;
    prod_q <= mul_a * mul_b;
  end

  gwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .long_i     (div_long),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  gwc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   ({s_q[47:0], 16'd0}),
    .stat_o  (sq_stat),
    .root_o  (sq_root)
  );

  gwc_ram #(
    .WIDTH ($bits(gwc_pkg::dist_t)),
    .DEPTH (DDEPTH)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (dist_waddr),
    .wdata_i (dist_wdata),
    .raddr_i (dist_raddr),
    .rdata_o (dist_rd)
  );

  gwc_ram #(
    .WIDTH ($bits(gwc_pkg::thr_t)),
    .DEPTH (NUM_FEATURES)
  ) u_thr_ram (
    .clk_i   (clk_i),
    .we_i    (thr_we),
    .waddr_i (thr_waddr),
    .wdata_i (thr_wdata),
    .raddr_i (thr_raddr),
    .rdata_o (thr_rd)
  );

  assign in_stall_o  = (state_q != S_IDLE) || clr_act_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // No item enters during the clearing pass
  a_clr_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_act_q |-> in_stall_o)
    else $error("item accepted during clearing pass");

  // Gain stays within its clamp range
  a_gain_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_D1) |-> (k_q >= gwc_pkg::MIN_GAIN && k_q <= gwc_pkg::GAIN_ONE))
    else $error("sigma gain out of range");

  // Stored sigma is clamped
  a_sigma_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_we && !clr_act_q) |->
      (dist_wdata.sigma >= gwc_pkg::Q_ONE && dist_wdata.sigma <= gwc_pkg::SIGMA_MAX))
    else $error("sigma written out of range");

  // Divider is never restarted while stepping
  a_div_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

endmodule

// ===== hdl/gwc_ram.sv =====
module gwc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry through a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/gwc_div.sv =====
module gwc_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    long_i,
  input  logic [63:0]             dividend_i,
  input  logic [32:0]             divisor_i,
  output gwc_pkg::unit_status_t   stat_o,
  output logic [31:0]             quotient_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [33:0] rem_q, rem_d;
  logic [63:0] num_q, num_d;
  logic [32:0] den_q, den_d;
  logic [31:0] quo_q, quo_d;
  logic [33:0] trial;
  logic        ge;

  // One quotient bit per cycle, restoring
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    den_d  = den_q;
    quo_d  = quo_q;
    trial  = {rem_q[32:0], num_q[63]};
    ge     = (trial >= {1'b0, den_q});
    if (start_i) begin
      den_d = divisor_i;
      quo_d = '0;
      if (divisor_i == '0) begin
        // zero divisor: quotient zero
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        if (long_i) begin
          rem_d = {2'b00, dividend_i[63:32]};
          num_d = {dividend_i[31:0], 32'd0};
          cnt_d = gwc_pkg::DIV_LONG_STEPS;
        end else begin
          rem_d = dividend_i[50:17];
          num_d = {dividend_i[16:0], 47'd0};
          cnt_d = gwc_pkg::DIV_SHORT_STEPS;
        end
      end
    end else if (busy_q) begin
      rem_d = ge ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[30:0], ge};
      num_d = {num_q[62:0], 1'b0};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

endmodule

// ===== hdl/gwc_sqrt.sv =====
module gwc_sqrt (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [63:0]           rad_i,
  output gwc_pkg::unit_status_t stat_o,
  output logic [31:0]           root_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [33:0] rem_q, rem_d;
  logic [63:0] x_q, x_d;
  logic [31:0] root_q, root_d;
  logic [35:0] r2, trial, r2_sub;
  logic        ge;

  // One root bit per cycle, two radicand bits shifted in
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    x_d    = x_q;
    root_d = root_q;
    r2     = {rem_q, x_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = (r2 >= trial);
    r2_sub = r2 - trial;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = '0;
      root_d = '0;
      x_d    = rad_i;
      cnt_d  = gwc_pkg::SQRT_STEPS;
    end else if (busy_q) begin
      rem_d  = ge ? r2_sub[33:0] : r2[33:0];
      root_d = {root_q[30:0], ge};
      x_d    = {x_q[61:0], 2'b00};
      cnt_d  = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    x_q    <= x_d;
    root_q <= root_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign root_o      = root_q;

endmodule

// ===== tb/sv/gaussian_weak_classifier_bank_checker.sv =====
`timescale 1ns / 100ps
module gaussian_weak_classifier_bank_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  gwc_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  gwc_pkg::out_t out_data_i,
  input  logic          cfg_we_i,
  input  logic [gwc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gwc_pkg::REG_W-1:0]     cfg_wdata_i,
  output int            fail_count_o,
  output int            pending_o
);

  localparam int NF = 256;

  // Shadow copy of the bank and its registers
  logic [30:0]        init_cov_q, mean_noise_q, sigma_noise_q;
  logic signed [31:0] mean_m   [2*NF];
  logic [31:0]        sigma_m  [2*NF];
  logic [31:0]        pmean_m  [2*NF];
  logic [31:0]        psigma_m [2*NF];
  logic signed [31:0] thr_m    [NF];
  logic [1:0]         par_m    [NF];
  gwc_pkg::out_t      expected_q[$];

  assign pending_o = expected_q.size();

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // Floor division by 2^16 (arithmetic shift floors)
  function automatic longint fl16(longint t);
    return t >>> 16;
  endfunction

  function automatic longint unsigned gain(longint unsigned p, longint unsigned r);
    longint unsigned den, k;
    den = p + r;
    k = (den != 0) ? ((p << 16) / den) : 0;
    return (k < 66) ? 64'd66 : k;
  endfunction

  function automatic longint unsigned shrink(longint unsigned p, longint unsigned r);
    longint unsigned den;
    den = p + r;
    return (den != 0) ? (p * r) / den : 0;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned rem, res, b;
    rem = x; res = 0; b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  task automatic clear_bank();
    for (int i = 0; i < 2*NF; i++) begin
      mean_m[i] = '0; sigma_m[i] = 32'd65536;
      pmean_m[i] = {1'b0, init_cov_q}; psigma_m[i] = {1'b0, init_cov_q};
    end
    for (int i = 0; i < NF; i++) begin
      thr_m[i] = '0; par_m[i] = gwc_pkg::PAR_ZERO;
    end
  endtask

  // Kalman step on one Gaussian
  function automatic void update_gaussian(int d, longint v);
    longint unsigned p, k, ad, sig, s, sq;
    longint m, diff;
    p = pmean_m[d];
    k = gain(p, mean_noise_q);
    m = fl16(longint'(k) * v + longint'(65536 - k) * longint'(mean_m[d]) + 32768);
    m = sat32(m);
    mean_m[d] = m[31:0];
    pmean_m[d] = 32'(shrink(p, mean_noise_q));
    p = psigma_m[d];
    k = gain(p, sigma_noise_q);
    diff = m - v;
    ad = (diff < 0) ? -diff : diff;
    sig = sigma_m[d] & 32'h7FFF_FFFF;
    s = ((((ad * ad) >> 16) * k) >> 16) + ((((sig * sig) >> 16) * (65536 - k)) >> 16);
    psigma_m[d] = 32'(shrink(p, sigma_noise_q));
    if (s >= (64'd1 << 48)) sq = 64'h7FFF_FFFF;
    else begin
      sq = int_sqrt(s << 16);
      if (sq > 64'h7FFF_FFFF) sq = 64'h7FFF_FFFF;
    end
    if (sq <= 65536) sq = 65536;
    sigma_m[d] = sq[31:0];
  endfunction

  function automatic gwc_pkg::out_t classify_item(gwc_pkg::in_t it);
    gwc_pkg::out_t r;
    int f;
    longint v, mfg, mbg, diff;
    logic hyp;
    f = it.feature_index % NF;
    v = it.response_value;
    if (it.op == 1'b0) begin
      update_gaussian(2*f + (it.is_foreground ? 1 : 0), v);
      mfg = mean_m[2*f+1];
      mbg = mean_m[2*f];
      thr_m[f] = 32'(sat32(fl16((mfg + mbg) * 32768)));
      par_m[f] = (mfg > mbg) ? gwc_pkg::PAR_POS : gwc_pkg::PAR_NEG;
    end
    diff = v - longint'(thr_m[f]);
    if (par_m[f] == gwc_pkg::PAR_POS) hyp = diff > 0;
    else if (par_m[f] == gwc_pkg::PAR_NEG) hyp = diff < 0;
    else hyp = 1'b0;
    r.hypothesis_positive = hyp;
    r.misclassified = (it.op == 1'b0) && (hyp != it.is_foreground);
    r.decision_threshold = thr_m[f];
    r.parity_positive = (par_m[f] == gwc_pkg::PAR_POS);
    return r;
  endfunction

  // Track writes, predict accepted items, compare results
  always @(posedge clk_i) begin
    gwc_pkg::out_t exp_r;
    if (!rst_ni) begin
      init_cov_q    = gwc_pkg::INIT_COV_RST;
      mean_noise_q  = gwc_pkg::NOISE_RST;
      sigma_noise_q = gwc_pkg::NOISE_RST;
      clear_bank();
      expected_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          gwc_pkg::CFG_INIT_COV: begin
            init_cov_q = cfg_wdata_i;
            clear_bank();
          end
          gwc_pkg::CFG_MEAN_NOISE:  mean_noise_q = cfg_wdata_i;
          gwc_pkg::CFG_SIGMA_NOISE: sigma_noise_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("unexpected result %h", out_data_i);
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r !== out_data_i) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display("mismatch: exp hyp=%0b mis=%0b thr=%0d par=%0b",
                exp_r.hypothesis_positive, exp_r.misclassified,
                exp_r.decision_threshold, exp_r.parity_positive,
                ", got hyp=%0b mis=%0b thr=%0d par=%0b",
                out_data_i.hypothesis_positive, out_data_i.misclassified,
                out_data_i.decision_threshold, out_data_i.parity_positive);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_q = {expected_q, classify_item(in_data_i)};
    end
  end

endmodule

// ===== tb/sv/gaussian_weak_classifier_bank_tb.sv =====
`timescale 1ns / 100ps
module gaussian_weak_classifier_bank_tb;

  localparam int unsigned RW = gwc_pkg::REG_W;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, cfg_we;
  logic out_stall  = 1'b0;
  logic stall_mode = 1'b0;
  gwc_pkg::in_t  in_data;
  gwc_pkg::out_t out_data;
  logic [gwc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [RW-1:0]                 cfg_wdata;
  int   fail_count, pending;

  gaussian_weak_classifier_bank u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata)
  );

  gaussian_weak_classifier_bank_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // Receiver stall pattern: phases of no stall and of heavy stall
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_stall <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b0;
  end

  // Send one item, idling by bursts
  task automatic send_item(gwc_pkg::in_t it);
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic [gwc_pkg::CFG_IDX_W-1:0] idx, logic [RW-1:0] val);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    // clearing pass after a covariance write
    if (idx == gwc_pkg::CFG_INIT_COV) repeat (600) @(negedge clk);
  endtask

  function automatic gwc_pkg::in_t mk(logic op, logic [7:0] f, logic [31:0] v, logic fg);
    gwc_pkg::in_t it;
    it.op = op; it.feature_index = f; it.response_value = v; it.is_foreground = fg;
    return it;
  endfunction

  // Random value: mostly moderate, sometimes extreme
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      default: return 32'($signed(32'($urandom_range(0, 40 << 16))) - (20 << 16));
    endcase
  endfunction

  initial begin
    gwc_pkg::in_t it;
    logic [RW-1:0] cov_set [4];
    logic [RW-1:0] noise_set [4];
    rst_n = 1'b0; in_valid = 1'b0; cfg_we = 1'b0;
    cfg_idx = gwc_pkg::CFG_INIT_COV; cfg_wdata = '0; in_data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    repeat (600) @(negedge clk);

    // Directed: parity zero, extremes, both ops and classes, index extremes
    send_item(mk(1'b1, 8'd0, 32'h7FFF_FFFF, 1'b1));
    send_item(mk(1'b0, 8'd0, 32'h7FFF_FFFF, 1'b1));
    send_item(mk(1'b0, 8'd0, 32'h8000_0000, 1'b0));
    send_item(mk(1'b1, 8'd0, 32'd0, 1'b0));
    send_item(mk(1'b0, 8'd255, 32'hFFFF_FFFF, 1'b0));
    send_item(mk(1'b0, 8'd255, 32'd1, 1'b1));
    send_item(mk(1'b1, 8'd255, 32'h8000_0000, 1'b1));
    send_item(mk(1'b0, 8'd128, 32'h0001_0000, 1'b1));
    send_item(mk(1'b0, 8'd128, 32'h0001_0000, 1'b0));
    send_item(mk(1'b1, 8'd128, 32'h0001_0000, 1'b0));
    send_item(mk(1'b0, 8'd7, 32'h7FFF_FFFF, 1'b0));
    send_item(mk(1'b0, 8'd7, 32'h8000_0000, 1'b1));
    send_item(mk(1'b1, 8'd7, 32'h5555_5555, 1'b1));
    send_item(mk(1'b1, 8'd170, 32'hAAAA_AAAA, 1'b0));
    drain();

    cov_set   = '{31'd1, 31'h7FFF_FFFF, 31'd65536000, 31'd300000};
    noise_set = '{31'd1, 31'h7FFF_FFFF, 31'd655, 31'd50000};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(gwc_pkg::CFG_MEAN_NOISE,
                (ph < 4) ? noise_set[ph] : RW'($urandom_range(1, 200000)));
      write_reg(gwc_pkg::CFG_SIGMA_NOISE,
                (ph < 4) ? noise_set[3-ph] : RW'($urandom_range(1, 200000)));
      write_reg(gwc_pkg::CFG_INIT_COV,
                (ph < 4) ? cov_set[ph] : RW'($urandom_range(1, 1 << 27)));
      for (int n = 0; n < 140; n++) begin
        // Mostly updates on few features so their Gaussians evolve
        it = mk($urandom_range(0, 3) == 0, 8'($urandom_range(0, 7)), rand_value(),
                $urandom_range(0, 1) == 1);
        if ($urandom_range(0, 5) == 0) it.feature_index = 8'($urandom());
        send_item(it);
        if (n == 70) drain();
      end
      drain();
    end
    // Out-of-range register index is ignored
    write_reg(2'd3, RW'($urandom()));
    send_item(mk(1'b0, 8'd3, rand_value(), 1'b1));
    drain();

    if (fail_count == 0) begin
      $display("gaussian_weak_classifier_bank regression: pass");
    end else begin
      $display("gaussian_weak_classifier_bank regression: fail");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("gaussian_weak_classifier_bank regression: fail");
    $finish;
  end

endmodule

// ===== gaussian_weak_classifier_bank.f =====
hdl/gwc_pkg.sv
hdl/gwc_ram.sv
hdl/gwc_div.sv
hdl/gwc_sqrt.sv
hdl/gaussian_weak_classifier_bank.sv
tb/sv/gaussian_weak_classifier_bank_checker.sv
tb/sv/gaussian_weak_classifier_bank_tb.sv
